// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the button click classifier RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BCC_ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define BCC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BCC_ASSERT_HOLDS(label, clk, rst_n, expr)
`define BCC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/bcc_pkg.sv =====
// Types and constants of the button click classifier
package bcc_pkg;

    localparam int PIN_COUNT   = 3;
    localparam int TICK_W      = 16;
    localparam int BOUNCE_W    = 4;
    localparam int CLICK_W     = 2;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TICK_W-1:0]   TICK_MAX   = '1;
    localparam logic [BOUNCE_W-1:0] BOUNCE_MAX = '1;
    localparam logic [CLICK_W-1:0]  CLICK_MAX  = '1;
    localparam logic [CLICK_W-1:0]  CLICK_ONE  = CLICK_W'(1);
    localparam logic [CLICK_W-1:0]  CLICK_TWO  = CLICK_W'(2);

    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_MARK    = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_WAIT = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE     = CFG_INDEX_W'(3);

    localparam logic [TICK_W-1:0]   LONG_PRESS_RESET   = TICK_W'(50);
    localparam logic [TICK_W-1:0]   HOLD_MARK_RESET    = TICK_W'(30);
    localparam logic [TICK_W-1:0]   RELEASE_WAIT_RESET = TICK_W'(15);
    localparam logic [BOUNCE_W-1:0] DEBOUNCE_RESET     = BOUNCE_W'(3);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_WAIT    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    localparam logic [1:0] TOGGLE_NONE = 2'b00;
    localparam logic [1:0] TOGGLE_LED0 = 2'b01;
    localparam logic [1:0] TOGGLE_LED1 = 2'b10;
    localparam logic [1:0] TOGGLE_BOTH = 2'b11;

    typedef struct packed {
        logic [TICK_W-1:0]   long_press;
        logic [TICK_W-1:0]   hold_mark;
        logic [TICK_W-1:0]   release_wait;
        logic [BOUNCE_W-1:0] debounce;
    } cfg_t;

    typedef struct packed {
        logic [1:0] toggle;
        event_t     ev;
    } lane_out_t;

    typedef struct packed {
        logic   led_zero;
        logic   led_one;
        event_t ev0;
        event_t ev1;
        event_t ev2;
    } out_item_t;

endpackage

// ===== hdl/button_click_classifier.sv =====
// Top level of the button click classifier: config registers, lanes, merge, output stage
//
// One item per clock while s_ready is high: every tick enters one NUM_BUTTONS-wide bank
// of button lanes, each holding its own debounce counter, phase, tick counter and click
// counter, and the merge stage folds their LED toggles into the shared LED state in the
// same cycle. The result is registered for the m_ channel in a two-entry output stage
// (output register plus skid register) that keeps s_ready high until the skid register
// fills, so the sustained rate is one item per cycle while results are taken.
// cfg_ready is always high and a write takes effect for the next accepted item; indexes
// beyond the register list are ignored.
`include "assert_macros.svh"

module button_click_classifier #(
    parameter int NUM_BUTTONS = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_button_0_pin,
    input  logic                               s_button_1_pin,
    input  logic                               s_button_2_pin,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_led_zero,
    output logic                               m_led_one,
    output logic [1:0]                         m_event_button_0,
    output logic [1:0]                         m_event_button_1,
    output logic [1:0]                         m_event_button_2,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    bcc_pkg::cfg_t       cfg_reg;
    logic                step;
    logic [bcc_pkg::PIN_COUNT-1:0] pins;
    bcc_pkg::lane_out_t  lane_res [NUM_BUTTONS];
    bcc_pkg::event_t     pin_ev [bcc_pkg::PIN_COUNT];
    logic [1:0]          led;
    bcc_pkg::out_item_t  item_new;
    bcc_pkg::out_item_t  out_reg;
    bcc_pkg::out_item_t  skid_reg;
    logic                out_valid_reg;
    logic                skid_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press   <= bcc_pkg::LONG_PRESS_RESET;
            cfg_reg.hold_mark    <= bcc_pkg::HOLD_MARK_RESET;
            cfg_reg.release_wait <= bcc_pkg::RELEASE_WAIT_RESET;
            cfg_reg.debounce     <= bcc_pkg::DEBOUNCE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bcc_pkg::CFG_LONG_PRESS:   cfg_reg.long_press   <= cfg_data;
                bcc_pkg::CFG_HOLD_MARK:    cfg_reg.hold_mark    <= cfg_data;
                bcc_pkg::CFG_RELEASE_WAIT: cfg_reg.release_wait <= cfg_data;
                bcc_pkg::CFG_DEBOUNCE:
                    cfg_reg.debounce <= cfg_data[bcc_pkg::BOUNCE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !skid_valid_reg;
    assign step    = s_valid && s_ready;
    assign pins    = {s_button_2_pin, s_button_1_pin, s_button_0_pin};

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        logic raw;
        if (b < bcc_pkg::PIN_COUNT) begin : g_pin
            assign raw = pins[b];
        end else begin : g_idle
            assign raw = 1'b1;
        end
        bcc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step    (step),
            .raw     (raw),
            .cfg     (cfg_reg),
            .result  (lane_res[b])
        );
    end

    for (genvar p = 0; p < bcc_pkg::PIN_COUNT; p++) begin : g_event
        if (p < NUM_BUTTONS) begin : g_used
            assign pin_ev[p] = lane_res[p].ev;
        end else begin : g_absent
            assign pin_ev[p] = bcc_pkg::EV_NONE;
        end
    end

    bcc_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .lane_res (lane_res),
        .led      (led)
    );

    always_comb begin
        item_new.led_zero = led[0];
        item_new.led_one  = led[1];
        item_new.ev0      = pin_ev[0];
        item_new.ev1      = pin_ev[1];
        item_new.ev2      = pin_ev[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= step;
            end
        end else if (step) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (step) begin
                out_reg <= item_new;
            end
        end else if (step) begin
            skid_reg <= item_new;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_led_zero       = out_reg.led_zero;
    assign m_led_one        = out_reg.led_one;
    assign m_event_button_0 = out_reg.ev0;
    assign m_event_button_1 = out_reg.ev1;
    assign m_event_button_2 = out_reg.ev2;

    `BCC_ASSERT_IMPLIES(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `BCC_ASSERT_NEXT(a_out_held_on_stall, aclk, aresetn, out_valid_reg && !m_ready, out_valid_reg && $stable(out_reg))
    `BCC_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_valid_reg && m_ready, !skid_valid_reg && out_valid_reg)

endmodule

// ===== hdl/bcc_lane.sv =====
// Per-button lane: debounce filter and click classification state machine
`include "assert_macros.svh"

module bcc_lane (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic               raw,
    input  bcc_pkg::cfg_t      cfg,
    output bcc_pkg::lane_out_t result
);

    logic                              stable_reg, stable_next;
    bcc_pkg::phase_t                   phase_reg, phase_next;
    logic [bcc_pkg::TICK_W-1:0]        elapsed_reg, elapsed_next;
    logic [bcc_pkg::BOUNCE_W-1:0]      bounce_reg, bounce_next;
    logic [bcc_pkg::CLICK_W-1:0]       click_reg, click_next;

    logic [bcc_pkg::TICK_W-1:0]        elapsed_inc;
    logic [bcc_pkg::BOUNCE_W-1:0]      bounce_inc;

    always_comb begin
        elapsed_inc = elapsed_reg;
        if (phase_reg != bcc_pkg::PH_IDLE && elapsed_reg != bcc_pkg::TICK_MAX) begin
            elapsed_inc = elapsed_reg + bcc_pkg::TICK_W'(1);
        end
        bounce_inc = (bounce_reg != bcc_pkg::BOUNCE_MAX)
                   ? bounce_reg + bcc_pkg::BOUNCE_W'(1) : bounce_reg;
        stable_next = stable_reg;
        bounce_next = '0;
        if (stable_reg != raw) begin
            if (bounce_inc >= cfg.debounce) begin
                stable_next = raw;
            end else begin
                bounce_next = bounce_inc;
            end
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_inc;
        click_next   = click_reg;
        case (phase_reg)
            bcc_pkg::PH_IDLE: begin
                if (!stable_next) begin
                    elapsed_next = '0;
                    click_next   = bcc_pkg::CLICK_ONE;
                    phase_next   = bcc_pkg::PH_PRESSED;
                end
            end
            bcc_pkg::PH_PRESSED: begin
                if (stable_next) begin
                    if (elapsed_inc >= cfg.long_press) begin
                        phase_next = bcc_pkg::PH_IDLE;
                    end else begin
                        elapsed_next = '0;
                        phase_next   = bcc_pkg::PH_WAIT;
                    end
                end else if (elapsed_inc >= cfg.hold_mark) begin
                    click_next = '0;
                end
            end
            bcc_pkg::PH_WAIT: begin
                if (elapsed_inc >= cfg.release_wait) begin
                    phase_next = bcc_pkg::PH_IDLE;
                end else if (!stable_next) begin
                    if (click_reg != bcc_pkg::CLICK_MAX) begin
                        click_next = click_reg + bcc_pkg::CLICK_W'(1);
                    end
                    elapsed_next = '0;
                    phase_next   = bcc_pkg::PH_PRESSED;
                end
            end
            default: begin
                phase_next = bcc_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        result.ev     = bcc_pkg::EV_NONE;
        result.toggle = bcc_pkg::TOGGLE_NONE;
        case (phase_reg)
            bcc_pkg::PH_PRESSED: begin
                if (stable_next && elapsed_inc >= cfg.long_press) begin
                    result.ev     = bcc_pkg::EV_LONG;
                    result.toggle = bcc_pkg::TOGGLE_BOTH;
                end
            end
            bcc_pkg::PH_WAIT: begin
                if (elapsed_inc >= cfg.release_wait) begin
                    if (click_reg == bcc_pkg::CLICK_ONE) begin
                        result.ev     = bcc_pkg::EV_SINGLE;
                        result.toggle = bcc_pkg::TOGGLE_LED0;
                    end else if (click_reg == bcc_pkg::CLICK_TWO) begin
                        result.ev     = bcc_pkg::EV_DOUBLE;
                        result.toggle = bcc_pkg::TOGGLE_LED1;
                    end
                end
            end
            default: begin
                result.ev     = bcc_pkg::EV_NONE;
                result.toggle = bcc_pkg::TOGGLE_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg  <= 1'b1;
            phase_reg   <= bcc_pkg::PH_IDLE;
            elapsed_reg <= '0;
            bounce_reg  <= '0;
            click_reg   <= '0;
        end else if (step) begin
            stable_reg  <= stable_next;
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            bounce_reg  <= bounce_next;
            click_reg   <= click_next;
        end
    end

    `BCC_ASSERT_IMPLIES(a_idle_no_event, aclk, aresetn, phase_reg == bcc_pkg::PH_IDLE, result.ev == bcc_pkg::EV_NONE)
    `BCC_ASSERT_IMPLIES(a_long_toggles_both, aclk, aresetn, result.ev == bcc_pkg::EV_LONG, result.toggle == bcc_pkg::TOGGLE_BOTH)
    `BCC_ASSERT_NEXT(a_hold_without_step, aclk, aresetn, !step, $stable(phase_reg) && $stable(elapsed_reg) && $stable(click_reg))

endmodule

// ===== hdl/bcc_merge.sv =====
// Merge stage: combines lane toggles into the LED state
module bcc_merge #(
    parameter int NUM_BUTTONS = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  bcc_pkg::lane_out_t lane_res [NUM_BUTTONS],
    output logic [1:0]         led
);

    logic [1:0] led_reg;
    logic [1:0] toggle_all;

    always_comb begin
        toggle_all = bcc_pkg::TOGGLE_NONE;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            toggle_all = toggle_all ^ lane_res[b].toggle;
        end
    end

    assign led = led_reg ^ toggle_all;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_reg <= 2'b00;
        end else if (step) begin
            led_reg <= led;
        end
    end

endmodule

// ===== tb/click_event_checker.sv =====
`timescale 1ns / 100ps
// Checker of the button click classifier: predicts LED state and click events per tick
module click_event_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_button_0_pin,
    input  logic                            s_button_1_pin,
    input  logic                            s_button_2_pin,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_led_zero,
    input  logic                            m_led_one,
    input  logic [1:0]                      m_event_button_0,
    input  logic [1:0]                      m_event_button_1,
    input  logic [1:0]                      m_event_button_2,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              results_owed
);
    import bcc_pkg::*;

    logic [PIN_COUNT-1:0] stable_lvl;
    phase_t               phase_now [PIN_COUNT];
    logic [TICK_W-1:0]    ticks     [PIN_COUNT];
    logic [BOUNCE_W-1:0]  bounce    [PIN_COUNT];
    logic [CLICK_W-1:0]   clicks    [PIN_COUNT];
    logic [1:0]           leds;
    cfg_t                 cfg;
    out_item_t            led_event_q [$];
    int                   errors = 0;
    int                   owed = 0;

    assign fail_count   = errors;
    assign results_owed = owed;

    function automatic event_t step_button(int b, logic raw);
        event_t ev;
        ev = EV_NONE;
        if (phase_now[b] != PH_IDLE && ticks[b] != TICK_MAX) begin
            ticks[b]++;
        end
        if (stable_lvl[b] != raw) begin
            if (bounce[b] != BOUNCE_MAX) begin
                bounce[b]++;
            end
            if (bounce[b] >= cfg.debounce) begin
                stable_lvl[b] = raw;
                bounce[b] = '0;
            end
        end else begin
            bounce[b] = '0;
        end
        case (phase_now[b])
            PH_IDLE: begin
                if (!stable_lvl[b]) begin
                    ticks[b] = '0;
                    clicks[b] = CLICK_ONE;
                    phase_now[b] = PH_PRESSED;
                end
            end
            PH_PRESSED: begin
                if (stable_lvl[b]) begin
                    if (ticks[b] >= cfg.long_press) begin
                        leds ^= TOGGLE_BOTH;
                        phase_now[b] = PH_IDLE;
                        ev = EV_LONG;
                    end else begin
                        ticks[b] = '0;
                        phase_now[b] = PH_WAIT;
                    end
                end else if (ticks[b] >= cfg.hold_mark) begin
                    clicks[b] = '0;
                end
            end
            PH_WAIT: begin
                if (ticks[b] >= cfg.release_wait) begin
                    phase_now[b] = PH_IDLE;
                    if (clicks[b] == CLICK_ONE) begin
                        leds ^= TOGGLE_LED0;
                        ev = EV_SINGLE;
                    end else if (clicks[b] == CLICK_TWO) begin
                        leds ^= TOGGLE_LED1;
                        ev = EV_DOUBLE;
                    end
                end else if (!stable_lvl[b]) begin
                    if (clicks[b] != CLICK_MAX) begin
                        clicks[b]++;
                    end
                    ticks[b] = '0;
                    phase_now[b] = PH_PRESSED;
                end
            end
            default: begin
                phase_now[b] = PH_IDLE;
            end
        endcase
        return ev;
    endfunction

    function automatic out_item_t classify_tick(logic [PIN_COUNT-1:0] pins);
        out_item_t r;
        event_t    ev [PIN_COUNT];
        for (int b = 0; b < PIN_COUNT; b++) begin
            ev[b] = step_button(b, pins[b]);
        end
        r.led_zero = leds[0];
        r.led_one  = leds[1];
        r.ev0      = ev[0];
        r.ev1      = ev[1];
        r.ev2      = ev[2];
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            cfg.long_press   = LONG_PRESS_RESET;
            cfg.hold_mark    = HOLD_MARK_RESET;
            cfg.release_wait = RELEASE_WAIT_RESET;
            cfg.debounce     = DEBOUNCE_RESET;
            stable_lvl = '1;
            leds = '0;
            for (int b = 0; b < PIN_COUNT; b++) begin
                phase_now[b] = PH_IDLE;
                ticks[b]     = '0;
                bounce[b]    = '0;
                clicks[b]    = '0;
            end
            led_event_q.delete();
            owed <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LONG_PRESS:   cfg.long_press   = cfg_data;
                    CFG_HOLD_MARK:    cfg.hold_mark    = cfg_data;
                    CFG_RELEASE_WAIT: cfg.release_wait = cfg_data;
                    CFG_DEBOUNCE:     cfg.debounce     = cfg_data[BOUNCE_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (led_event_q.size() == 0) begin
                    $error("result item with no tick awaiting a result");
                    errors++;
                end else begin
                    want = led_event_q.pop_front();
                    check_field("led_zero", want.led_zero, m_led_zero);
                    check_field("led_one", want.led_one, m_led_one);
                    check_field("event_button_0", want.ev0, m_event_button_0);
                    check_field("event_button_1", want.ev1, m_event_button_1);
                    check_field("event_button_2", want.ev2, m_event_button_2);
                end
            end
            if (s_valid && s_ready) begin
                led_event_q.push_back(
                    classify_tick({s_button_2_pin, s_button_1_pin, s_button_0_pin}));
            end
            owed <= led_event_q.size();
        end
    end

endmodule

// ===== tb/button_click_classifier_tb.sv =====
`timescale 1ns / 100ps
// Testbench top of the button click classifier: clock, reset, stimulus and verdict
module button_click_classifier_tb;
    import bcc_pkg::*;

    localparam int STUCK_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int HOLD_TICKS      = 24;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [PIN_COUNT-1:0]   s_pins = '1;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_led_zero;
    logic                   m_led_one;
    logic [1:0]             m_event_button_0;
    logic [1:0]             m_event_button_1;
    logic [1:0]             m_event_button_2;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int results_owed;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_asked = 0;
    int hold_off_served = 0;
    int hold_off_left = 0;
    int stuck_cycles = 0;

    int cur_long = LONG_PRESS_RESET;
    int cur_hold = HOLD_MARK_RESET;
    int cur_wait = RELEASE_WAIT_RESET;
    int cur_deb  = DEBOUNCE_RESET;

    logic pin_level  [PIN_COUNT] = '{default: 1'b1};
    int   run_left   [PIN_COUNT] = '{default: 0};
    int   burst_left [PIN_COUNT] = '{default: 0};

    button_click_classifier DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_button_0_pin   (s_pins[0]),
        .s_button_1_pin   (s_pins[1]),
        .s_button_2_pin   (s_pins[2]),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_led_zero       (m_led_zero),
        .m_led_one        (m_led_one),
        .m_event_button_0 (m_event_button_0),
        .m_event_button_1 (m_event_button_1),
        .m_event_button_2 (m_event_button_2),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    click_event_checker tick_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_button_0_pin   (s_pins[0]),
        .s_button_1_pin   (s_pins[1]),
        .s_button_2_pin   (s_pins[2]),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_led_zero       (m_led_zero),
        .m_led_one        (m_led_one),
        .m_event_button_0 (m_event_button_0),
        .m_event_button_1 (m_event_button_1),
        .m_event_button_2 (m_event_button_2),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .results_owed     (results_owed)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_off_left <= 0;
        end else if (hold_off_left != 0) begin
            m_ready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else if (hold_off_asked != hold_off_served) begin
            m_ready <= 1'b0;
            hold_off_served <= hold_off_asked;
            hold_off_left <= HOLD_OFF_CYCLES;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[button_click_classifier] ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_tick(input logic [PIN_COUNT-1:0] pins);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pins <= pins;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_run(input logic [PIN_COUNT-1:0] pins, input int count);
        repeat (count) send_tick(pins);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_setting(input int long_t, input int hold_t, input int wait_t,
                                 input logic [CFG_DATA_W-1:0] deb_word,
                                 input bit stray_writes);
        wait_idle();
        write_reg(CFG_LONG_PRESS, CFG_DATA_W'(long_t));
        write_reg(CFG_HOLD_MARK, CFG_DATA_W'(hold_t));
        write_reg(CFG_RELEASE_WAIT, CFG_DATA_W'(wait_t));
        write_reg(CFG_DEBOUNCE, deb_word);
        if (stray_writes) begin
            for (int i = CFG_DEBOUNCE + 1; i < (1 << CFG_INDEX_W); i++) begin
                write_reg(CFG_INDEX_W'(i), (i % 2 != 0) ? '1 : CFG_DATA_W'($urandom));
            end
        end
        cfg_valid <= 1'b0;
        cur_long = long_t;
        cur_hold = hold_t;
        cur_wait = wait_t;
        cur_deb  = deb_word[BOUNCE_W-1:0];
    endtask

    function automatic int press_len();
        int r;
        r = $urandom_range(9);
        if (r < 5) begin
            return cur_deb + $urandom_range(1, (cur_hold > 1) ? cur_hold - 1 : 1);
        end
        if (r < 8) begin
            return cur_deb + $urandom_range(cur_hold, (cur_long > cur_hold) ? cur_long : cur_hold);
        end
        return cur_deb + cur_long + $urandom_range(0, 6);
    endfunction

    // press, release in click bursts, glitch now and then
    task automatic next_pins(output logic [PIN_COUNT-1:0] pins);
        for (int b = 0; b < PIN_COUNT; b++) begin
            if (run_left[b] <= 0) begin
                pin_level[b] = ~pin_level[b];
                if (!pin_level[b]) begin
                    run_left[b] = press_len();
                end else if (burst_left[b] > 0) begin
                    burst_left[b]--;
                    run_left[b] = cur_deb + $urandom_range(1, cur_wait / 2 + 1);
                end else begin
                    burst_left[b] = $urandom_range(0, 3);
                    run_left[b] = cur_deb + cur_wait + $urandom_range(2, 12);
                end
                if (run_left[b] < 1) begin
                    run_left[b] = 1;
                end
            end
            run_left[b]--;
            pins[b] = pin_level[b] ^ ($urandom_range(99) < 4);
        end
    endtask

    task automatic run_random(input int count, input int hold_off_at);
        logic [PIN_COUNT-1:0] pins;
        for (int i = 0; i < count; i++) begin
            if (i == hold_off_at) begin
                hold_off_asked <= hold_off_asked + 1;
            end
            next_pins(pins);
            send_tick(pins);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct <= 36;
        recv_idle_pct <= 74;
        run_random(40, -1);

        apply_setting(6, 4, 3, CFG_DATA_W'(1), 1'b0);
        send_run(3'b111, 2);
        send_run(3'b000, 2);
        send_run(3'b111, 4);
        send_run(3'b110, 1);
        send_run(3'b111, 1);
        send_run(3'b110, 1);
        send_run(3'b111, 3);
        send_run(3'b001, 7);
        send_run(3'b111, 4);

        apply_setting(12, 8, 5, CFG_DATA_W'(2), 1'b0);
        run_random(130, -1);

        send_idle_pct <= 74;
        recv_idle_pct <= 36;
        apply_setting(20, 10, 7, CFG_DATA_W'(4), 1'b0);
        run_random(130, -1);

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        apply_setting(40, 0, 0, 16'hFFF0, 1'b1);
        run_random(60, 20);

        apply_setting(0, 1, 1, 16'hA5AF, 1'b0);
        run_random(80, -1);

        // hold button 0 under top thresholds, click button 1, single press on button 2
        apply_setting(65535, 65535, 65535, CFG_DATA_W'(1), 1'b0);
        for (int i = 0; i < HOLD_TICKS; i++) begin
            send_tick({(i < 5) ? 1'b0 : 1'b1, i[3], 1'b0});
        end
        send_run(3'b111, 20);

        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[button_click_classifier] OK");
        end else begin
            $display("[button_click_classifier] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bcc_pkg.sv
hdl/bcc_lane.sv
hdl/bcc_merge.sv
hdl/button_click_classifier.sv
tb/click_event_checker.sv
tb/button_click_classifier_tb.sv
